// ----- src/fpa_pkg.sv -----
package fpa_pkg;

    localparam int FRAC_BITS = 8;
    localparam int DATA_W    = 32;

    // divider widths: numerator is 2*(|a| << FRAC_BITS) + |b|, divisor 2*|b|
    localparam int NUM_W   = DATA_W + FRAC_BITS;
    localparam int N_W     = NUM_W + 1;
    localparam int D_W     = DATA_W + 1;
    localparam int PROD_W  = 2 * DATA_W;

    // input register, setup stage, one stage per quotient bit, output stage
    localparam int DEPTH     = N_W + 3;
    localparam int DIV_FIRST = 2;

    typedef enum logic [3:0] {
        FN_ADD     = 4'd0,
        FN_SUB     = 4'd1,
        FN_MUL     = 4'd2,
        FN_DIV     = 4'd3,
        FN_GT      = 4'd4,
        FN_LT      = 4'd5,
        FN_GE      = 4'd6,
        FN_LE      = 4'd7,
        FN_EQ      = 4'd8,
        FN_NE      = 4'd9,
        FN_MIN     = 4'd10,
        FN_MAX     = 4'd11,
        FN_INC     = 4'd12,
        FN_DEC     = 4'd13,
        FN_TOINT   = 4'd14,
        FN_FROMINT = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_DIV_ZERO = 2'd1,
        ST_OVERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic                     valid;
        t_func                    func;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        logic signed [DATA_W-1:0] res;
        logic                     flag;
        t_status                  status;
        logic                     neg;
        logic [D_W-1:0]           den;
        logic [D_W-1:0]           rem;
        logic [N_W-1:0]           quo;
    } t_stage;

endpackage

// ----- src/fpa_if.sv -----
interface fpa_in_if import fpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    t_func                    func;
    logic signed [DATA_W-1:0] operand_a;
    logic signed [DATA_W-1:0] operand_b;

    modport source (output valid, func, operand_a, operand_b, input ready);
    modport sink   (input valid, func, operand_a, operand_b, output ready);
endinterface

interface fpa_out_if import fpa_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] result;
    logic                     flag;
    t_status                  status;

    modport source (output valid, result, flag, status, input ready);
    modport sink   (input valid, result, flag, status, output ready);
endinterface

// ----- src/fixed_point_alu.sv -----
// Q24.8 fixed-point ALU. Every operation runs through one pipeline of
// DEPTH = 44 register stages (input register, operand setup and 32x32
// magnitude multiply, then one restoring-division stage per quotient bit,
// 41 of them, then sign and overflow fix-up). An item passes through the
// stages in this order and its result leaves from the fix-up stage. One
// item is taken every cycle unless the pipeline holds. The depth is set by
// the bit-per-stage divider; other operations ride along so results leave
// in order. When the output item is not taken the whole pipeline holds;
// ready drops only while the last stage holds an item that is not being
// taken. Overflow wraps to 32 bits and reports status 2; division by zero
// gives result 0 and status 1.
module fixed_point_alu import fpa_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fpa_in_if.sink    i_in,
    fpa_out_if.source o_out
);

    localparam logic [N_W-1:0] LIM_NEG = N_W'(64'h8000_0000);
    localparam logic [N_W-1:0] LIM_POS = N_W'(64'h7FFF_FFFF);
    localparam logic [PROD_W-1:0] P_LIM_NEG = PROD_W'(64'h8000_0000);
    localparam logic [PROD_W-1:0] P_LIM_POS = PROD_W'(64'h7FFF_FFFF);
    localparam logic [PROD_W-1:0] P_HALF = PROD_W'(1) << (FRAC_BITS - 1);

    t_stage r_pipe [DEPTH];
    t_stage n_pipe [DEPTH];
    logic [PROD_W-1:0] r_prod;
    logic [PROD_W-1:0] n_prod;
    logic              w_en;

    // whole pipeline advances unless the finished item is stuck
    assign w_en       = !r_pipe[DEPTH-1].valid || o_out.ready;
    assign i_in.ready = w_en;

    always_comb begin
        logic [DATA_W-1:0]   v_abs_a;
        logic [DATA_W-1:0]   v_abs_b;
        logic [DATA_W:0]     v_sum;
        logic [D_W:0]        v_sh;
        logic [PROD_W-1:0]   v_pmag;
        logic [N_W-1:0]      v_q;
        logic                v_ovf;
        t_stage              s;

        v_pmag = '0;
        v_ovf  = 1'b0;

        // stage 0: capture the item
        n_pipe[0]        = r_pipe[0];
        n_pipe[0].valid  = i_in.valid;
        n_pipe[0].func   = i_in.func;
        n_pipe[0].a      = i_in.operand_a;
        n_pipe[0].b      = i_in.operand_b;

        // stage 1: simple operations, multiply and divider setup
        s        = r_pipe[0];
        v_abs_a  = s.a[DATA_W-1] ? DATA_W'(-s.a) : DATA_W'(s.a);
        v_abs_b  = s.b[DATA_W-1] ? DATA_W'(-s.b) : DATA_W'(s.b);
        n_prod   = PROD_W'(v_abs_a) * PROD_W'(v_abs_b);
        s.res    = '0;
        s.flag   = 1'b0;
        s.status = ST_OK;
        s.neg    = s.a[DATA_W-1] ^ s.b[DATA_W-1];
        s.den    = {v_abs_b, 1'b0};
        s.rem    = '0;
        s.quo    = {v_abs_a, {FRAC_BITS{1'b0}}, 1'b0} + N_W'(v_abs_b);
        v_sum    = '0;
        case (s.func)
            FN_ADD:  v_sum = {s.a[DATA_W-1], s.a} + {s.b[DATA_W-1], s.b};
            FN_SUB:  v_sum = {s.a[DATA_W-1], s.a} - {s.b[DATA_W-1], s.b};
            FN_INC:  v_sum = {s.a[DATA_W-1], s.a} + (DATA_W+1)'(1);
            FN_DEC:  v_sum = {s.a[DATA_W-1], s.a} - (DATA_W+1)'(1);
            default: v_sum = '0;
        endcase
        case (s.func)
            FN_ADD, FN_SUB, FN_INC, FN_DEC: begin
                s.res = v_sum[DATA_W-1:0];
                if (v_sum[DATA_W] != v_sum[DATA_W-1]) s.status = ST_OVERFLOW;
            end
            FN_DIV: begin
                if (s.b == '0) s.status = ST_DIV_ZERO;
            end
            FN_GT:  s.flag = s.a >  s.b;
            FN_LT:  s.flag = s.a <  s.b;
            FN_GE:  s.flag = s.a >= s.b;
            FN_LE:  s.flag = s.a <= s.b;
            FN_EQ:  s.flag = s.a == s.b;
            FN_NE:  s.flag = s.a != s.b;
            FN_MIN: s.res  = (s.a < s.b) ? s.a : s.b;
            FN_MAX: s.res  = (s.a > s.b) ? s.a : s.b;
            FN_TOINT: s.res = s.a >>> FRAC_BITS;
            FN_FROMINT: begin
                s.res = s.a <<< FRAC_BITS;
                if (s.a[DATA_W-1:DATA_W-1-FRAC_BITS] != '0 &&
                    s.a[DATA_W-1:DATA_W-1-FRAC_BITS] != '1)
                    s.status = ST_OVERFLOW;
            end
            default: s.res = '0;
        endcase
        n_pipe[1] = s;

        // division steps, one quotient bit each; first one also rounds mul
        for (int i = DIV_FIRST; i < DEPTH - 1; i++) begin
            s    = r_pipe[i-1];
            v_sh = {s.rem, s.quo[N_W-1]};
            if (v_sh >= {1'b0, s.den}) begin
                s.rem = D_W'(v_sh - {1'b0, s.den});
                s.quo = {s.quo[N_W-2:0], 1'b1};
            end else begin
                s.rem = v_sh[D_W-1:0];
                s.quo = {s.quo[N_W-2:0], 1'b0};
            end
            if (i == DIV_FIRST && s.func == FN_MUL) begin
                v_pmag = (r_prod + P_HALF) >> FRAC_BITS;
                s.res  = s.neg ? DATA_W'(-v_pmag) : v_pmag[DATA_W-1:0];
                v_ovf  = s.neg ? (v_pmag > P_LIM_NEG) : (v_pmag > P_LIM_POS);
                if (v_ovf) s.status = ST_OVERFLOW;
            end
            n_pipe[i] = s;
        end

        // last stage: sign and range of the quotient
        s   = r_pipe[DEPTH-2];
        v_q = s.quo;
        if (s.func == FN_DIV && s.status != ST_DIV_ZERO) begin
            s.res = s.neg ? DATA_W'(-v_q) : v_q[DATA_W-1:0];
            v_ovf = s.neg ? (v_q > LIM_NEG) : (v_q > LIM_POS);
            if (v_ovf) s.status = ST_OVERFLOW;
        end
        n_pipe[DEPTH-1] = s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) r_pipe[i].valid <= 1'b0;
        end else if (w_en) begin
            r_prod <= n_prod;
            for (int i = 0; i < DEPTH; i++) r_pipe[i] <= n_pipe[i];
        end
    end

    assign o_out.valid  = r_pipe[DEPTH-1].valid;
    assign o_out.result = r_pipe[DEPTH-1].res;
    assign o_out.flag   = r_pipe[DEPTH-1].flag;
    assign o_out.status = r_pipe[DEPTH-1].status;

    // a true comparison never carries an error
    a_flag_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.flag |-> o_out.status == ST_OK)
        else $error("flag set with error status");

    // divide by zero reports zero
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.status == ST_DIV_ZERO |-> o_out.result == '0)
        else $error("nonzero result on divide by zero");

    // an empty output stage never holds off the input
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out.valid |-> i_in.ready)
        else $error("input stalled with empty output");

endmodule
